FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file hpe_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define HPE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define HPE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/hpe_pkg.sv
`timescale 1ns / 1ps
package hpe_pkg;

   localparam int NUM_COEFFS = 8;   // 2 .. 8
   localparam int FRAC_BITS  = 16;  // 0 .. 30
   localparam int NUM_STEPS  = NUM_COEFFS - 1;
   // each step: one multiply stage, one shift/add/saturate stage
   localparam int NUM_STAGES = 2 * NUM_STEPS;

   localparam int REG_COUNT  = 8;
   localparam int COEF_IDX_W = 3;
   localparam int CSR_IDX_W  = 8;
   localparam int CNT_W      = $clog2(NUM_STAGES + 1);

   localparam logic signed [63:0] SUM_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SUM_MIN = -64'sd2147483648;

   typedef logic signed [31:0] word_type;
   typedef logic signed [63:0] wide_type;

endpackage

FILE: hw/rtl/horner_polynomial_evaluator_core.sv
`timescale 1ns / 1ps
// Horner evaluator, Q16.16. Each Horner step is one multiply stage and one
// shift/add/saturate stage. Throughput: one beat per cycle while rsp is not
// stalled; stages hand over by their own valid/ready, so empty stages fill
// while rsp stalls.
// Reset (synchronous): all coefficients to zero, pipeline emptied.
module horner_polynomial_evaluator_core
   import hpe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // [31:0] x_value
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // [31:0] poly_value
   output logic                 rsp_tuser,   // [0] saturated
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   word_type coef_ff [REG_COUNT];

   // multiply stages
   logic     vm_ff   [NUM_STEPS];
   wide_type prod_ff [NUM_STEPS];
   word_type xm_ff   [NUM_STEPS];
   logic     satm_ff [NUM_STEPS];
   // shift/add/saturate stages
   logic     va_ff   [NUM_STEPS];
   word_type acc_ff  [NUM_STEPS];
   word_type xa_ff   [NUM_STEPS];
   logic     sata_ff [NUM_STEPS];

   logic     rdy_m   [NUM_STEPS];
   logic     rdy_a   [NUM_STEPS];
   logic     mul_v   [NUM_STEPS];
   word_type mul_acc [NUM_STEPS];
   word_type mul_x   [NUM_STEPS];
   logic     mul_sat [NUM_STEPS];
   wide_type prod_in [NUM_STEPS];
   word_type acc_in  [NUM_STEPS];
   logic     sat_in  [NUM_STEPS];

   assign csr_ready = 1'b1;

   // ready chain, back to front
   always_comb begin
      for (int s = NUM_STEPS - 1; s >= 0; s--) begin
         if (s == NUM_STEPS - 1) begin
            rdy_a[s] = !va_ff[s] || rsp_tready;
         end else begin
            rdy_a[s] = !va_ff[s] || rdy_m[s + 1];
         end
         rdy_m[s] = !vm_ff[s] || rdy_a[s];
      end
   end

   assign req_tready = rdy_m[0];

   always_comb begin
      for (int s = 0; s < NUM_STEPS; s++) begin
         if (s == 0) begin
            mul_v[s]   = req_tvalid;
            mul_acc[s] = coef_ff[COEF_IDX_W'(NUM_COEFFS - 1)];
            mul_x[s]   = req_tdata;
            mul_sat[s] = 1'b0;
         end else begin
            mul_v[s]   = va_ff[s - 1];
            mul_acc[s] = acc_ff[s - 1];
            mul_x[s]   = xa_ff[s - 1];
            mul_sat[s] = sata_ff[s - 1];
         end
         prod_in[s] = mul_acc[s] * mul_x[s];
      end
   end

   always_comb begin
      wide_type sum;
      word_type c;
      for (int s = 0; s < NUM_STEPS; s++) begin
         c   = coef_ff[COEF_IDX_W'(NUM_COEFFS - 2 - s)];
         // floor shift; product magnitude stays within 2^62, no overflow
         sum = (prod_ff[s] >>> FRAC_BITS) + wide_type'(c);
         if (sum > SUM_MAX) begin
            acc_in[s] = SUM_MAX[31:0];
            sat_in[s] = 1'b1;
         end else if (sum < SUM_MIN) begin
            acc_in[s] = SUM_MIN[31:0];
            sat_in[s] = 1'b1;
         end else begin
            acc_in[s] = sum[31:0];
            sat_in[s] = satm_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            coef_ff[i] <= '0;
         end
         for (int s = 0; s < NUM_STEPS; s++) begin
            vm_ff[s] <= 1'b0;
            va_ff[s] <= 1'b0;
         end
      end else begin
         if (csr_valid && csr_index < CSR_IDX_W'(REG_COUNT)) begin
            coef_ff[csr_index[COEF_IDX_W-1:0]] <= csr_wdata;
         end
         for (int s = 0; s < NUM_STEPS; s++) begin
            if (rdy_m[s]) begin
               vm_ff[s] <= mul_v[s];
            end
            if (rdy_a[s]) begin
               va_ff[s] <= vm_ff[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NUM_STEPS; s++) begin
         if (rdy_m[s] && mul_v[s]) begin
            prod_ff[s] <= prod_in[s];
            xm_ff[s]   <= mul_x[s];
            satm_ff[s] <= mul_sat[s];
         end
         if (rdy_a[s] && vm_ff[s]) begin
            acc_ff[s]  <= acc_in[s];
            xa_ff[s]   <= xm_ff[s];
            sata_ff[s] <= sat_in[s];
         end
      end
   end

   assign rsp_tvalid = va_ff[NUM_STEPS - 1];
   assign rsp_tdata  = acc_ff[NUM_STEPS - 1];
   assign rsp_tuser  = sata_ff[NUM_STEPS - 1];

endmodule

FILE: hw/rtl/hpe_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hpe_checker
   import hpe_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             in_beat;
   logic             out_beat;

   assign in_beat  = req_tvalid && req_tready;
   assign out_beat = rsp_tvalid && rsp_tready;

   always_comb begin
      count_in = count_ff;
      if (in_beat && !out_beat) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!in_beat && out_beat) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // a result only when something is in flight
   `HPE_ASSERT(a_no_phantom, rsp_tvalid |-> count_ff != '0, "rsp beat with nothing in flight")
   // input held off only when every stage is full and the output is stalled
   `HPE_ASSERT(a_full_only, !req_tready |-> (count_ff == CNT_W'(NUM_STAGES) && rsp_tvalid && !rsp_tready), "req_tready low with room in the pipeline")
   `HPE_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled rsp beat changed")
   `HPE_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_tvalid && req_tready, "pipeline not empty after reset")

endmodule

bind horner_polynomial_evaluator_core hpe_checker u_hpe_checker (.*);

FILE: tb/sv/tb_horner_polynomial_evaluator_core.sv
`timescale 1ns / 1ps
module tb_horner_polynomial_evaluator_core;
   import hpe_pkg::*;

   localparam wide_type SAT_HI = 64'sd2147483647;
   localparam wide_type SAT_LO = -64'sd2147483648;
   localparam word_type Q_ONE  = 32'sh0001_0000;
   // longest honest silence is the counted receiver hold-off; allow plenty more
   localparam int QUIET_LIMIT  = 4000;

   typedef struct {
      word_type value;
      logic     sat;
   } poly_result_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata  = '0;    // [31:0] x_value
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;          // [31:0] poly_value
   logic                 rsp_tuser;          // [0] saturated
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [31:0]          csr_wdata  = '0;

   word_type        coef_model[REG_COUNT];
   word_type        coef_plan[REG_COUNT];
   poly_result_type pending_polys[$];
   int              mismatches    = 0;
   int              quiet_cycles  = 0;
   int              rsp_hold_left = 0;
   bit              feed_idling   = 1'b1;
   bit              rsp_idling    = 1'b1;

   horner_polynomial_evaluator_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Horner's rule with per-step clamping; later steps carry on from the clamp
   function automatic poly_result_type horner_eval(word_type x);
      poly_result_type res;
      wide_type        acc;
      wide_type        sum;
      int              k;
      res.sat = 1'b0;
      acc = coef_model[NUM_COEFFS-1];
      for (k = NUM_COEFFS - 2; k >= 0; k--) begin
         // >>> on a signed product floors, as required for negative products
         sum = ((acc * wide_type'(x)) >>> FRAC_BITS) + wide_type'(coef_model[k]);
         if (sum > SAT_HI) begin
            sum = SAT_HI;
            res.sat = 1'b1;
         end else if (sum < SAT_LO) begin
            sum = SAT_LO;
            res.sat = 1'b1;
         end
         acc = sum;
      end
      res.value = acc[31:0];
      return res;
   endfunction

   function automatic word_type pick_extreme();
      case ($urandom_range(3))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 32'sh0000_0000;
         default: return 32'shFFFF_FFFF;
      endcase
   endfunction

   // style 0: within +-4.0, 1: any word, 2: extremes, otherwise a mix
   function automatic word_type rand_coef(int style);
      word_type w;
      int       s;
      s = (style > 2) ? $urandom_range(2) : style;
      case (s)
         0: begin
            w = $urandom_range(0, 'h80000);
            w = w - 'sh40000;
         end
         1: w = $urandom;
         default: w = pick_extreme();
      endcase
      return w;
   endfunction

   function automatic word_type rand_point();
      word_type w;
      int       r;
      r = $urandom_range(99);
      if (r < 60) begin
         w = $urandom_range(0, 'h40000);
         w = w - 'sh20000;
      end else if (r < 90) begin
         w = $urandom;
      end else begin
         w = pick_extreme();
      end
      return w;
   endfunction

   function automatic void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("MISMATCH: %s", msg);
   endfunction

   // shadow of the coefficient file
   always @(posedge clock) begin
      if (reset) begin
         foreach (coef_model[i])
            coef_model[i] = '0;
      end else if (csr_valid && csr_ready && csr_index < REG_COUNT) begin
         coef_model[csr_index[COEF_IDX_W-1:0]] = csr_wdata;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         pending_polys.insert(pending_polys.size(), horner_eval(req_tdata));
   end

   always @(posedge clock) begin : check_results
      poly_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_polys.size() == 0) begin
            note_mismatch($sformatf("unexpected beat: value %h sat %b", rsp_tdata, rsp_tuser));
         end else begin
            want = pending_polys.pop_front();
            if (rsp_tdata !== want.value || rsp_tuser !== want.sat)
               note_mismatch($sformatf("value exp %h got %h, sat exp %b got %b",
                                       want.value, rsp_tdata, want.sat, rsp_tuser));
         end
      end
   end

   // receiver: random stalls while rsp_idling is set, or a counted hold-off when requested
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_tready <= !(rsp_idling && ($urandom_range(99) < 32));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("Timeout: no beat for %0d cycles", QUIET_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   // leaves tvalid high so back-to-back beats need no toggle
   task automatic send_point(input word_type x);
      if (feed_idling && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      do @(posedge clock); while (!req_tready);
   endtask

   // one edge first so the beat accepted at the last edge is already queued
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_polys.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input word_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_coef_plan();
      int i;
      drain_results();
      for (i = 0; i < REG_COUNT; i++)
         csr_put(CSR_IDX_W'(i), coef_plan[i]);
      csr_valid <= 1'b0;
   endtask

   task automatic fill_plan(input word_type v);
      foreach (coef_plan[i])
         coef_plan[i] = v;
   endtask

   task automatic test_reset_state();
      send_point(32'sh0000_0000);
      send_point(32'sh7FFF_FFFF);
      send_point(32'sh8000_0000);
   endtask

   task automatic test_directed_cases();
      // all ones: plain evaluation, fractional and tiny negative x (floor rounding)
      fill_plan(Q_ONE);
      write_coef_plan();
      send_point(32'sh0000_0000);
      send_point(Q_ONE);
      send_point(-Q_ONE);
      send_point(32'sh0000_8000);
      send_point(32'shFFFF_FFFF);
      // largest coefficients: clamps high and low
      fill_plan(32'sh7FFF_FFFF);
      write_coef_plan();
      send_point(32'sh7FFF_FFFF);
      send_point(32'sh8000_0000);
      send_point(32'sh0000_0000);
      fill_plan(32'sh8000_0000);
      write_coef_plan();
      send_point(32'sh7FFF_FFFF);
      send_point(32'sh8000_0000);
      send_point(Q_ONE);
      // clamp in an early step then recover; stray writes beyond the file are dropped
      drain_results();
      csr_put(CSR_IDX_W'(REG_COUNT), $urandom);
      csr_put('1, $urandom);
      fill_plan(Q_ONE);
      coef_plan[7] = 32'sh7FFF_FFFF;
      coef_plan[6] = 32'sh7FFF_FFFF;
      coef_plan[5] = 32'sh8000_0000;
      write_coef_plan();
      send_point(Q_ONE);
      send_point(-Q_ONE);
   endtask

   task automatic test_random_phases();
      int styles[6] = '{0, 0, 1, 2, 3, 0};
      int p;
      int n;
      feed_idling = 1'b1;
      rsp_idling  = 1'b1;
      for (p = 0; p < 6; p++) begin
         foreach (coef_plan[i])
            coef_plan[i] = rand_coef(styles[p]);
         write_coef_plan();
         for (n = 0; n < 140; n++)
            send_point(rand_point());
      end
   endtask

   task automatic test_output_backpressure();
      int n;
      feed_idling = 1'b0;
      rsp_idling  = 1'b0;
      foreach (coef_plan[i])
         coef_plan[i] = rand_coef(0);
      write_coef_plan();
      rsp_hold_left = 300;
      for (n = 0; n < 80; n++)
         send_point(rand_point());
   endtask

   task automatic test_back_to_back();
      int n;
      feed_idling = 1'b0;
      rsp_idling  = 1'b0;
      foreach (coef_plan[i])
         coef_plan[i] = rand_coef(3);
      write_coef_plan();
      for (n = 0; n < 120; n++)
         send_point(rand_point());
      feed_idling = 1'b1;
      rsp_idling  = 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_directed_cases();
      test_random_phases();
      test_output_backpressure();
      test_back_to_back();
      drain_results();
      repeat (NUM_STAGES + 4) @(posedge clock);
      if (pending_polys.size() != 0)
         $display("%0d results never arrived", pending_polys.size());
      if (mismatches == 0 && pending_polys.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
